[src/how_pkg.sv]
// how_pkg: shared types and constants of the horizontal offset warp block.
// No dependencies; imported by every module of the block.
package how_pkg;

   localparam int MAX_CHANNELS = 16;
   localparam int MAX_WIDTH    = 128;
   localparam int FRAC_BITS    = 8;

   localparam int CH_W    = $clog2(MAX_CHANNELS);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ADDR_W  = CH_W + COL_W;
   localparam int DEPTH   = MAX_CHANNELS * MAX_WIDTH;
   localparam int SMP_W   = 8;
   localparam int NCH_W   = 5;
   localparam int WID_W   = 8;
   localparam int CSR_W   = 8;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_WARP = 1'b1
   } op_type;

   typedef enum logic {
      REG_CHANNELS = 1'b0,
      REG_WIDTH    = 1'b1
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_ADD,
      S_SEND
   } state_type;

   typedef struct packed {
      logic mul_en;
      logic add_en;
   } interp_ctl_type;

endpackage

[src/horizontal_offset_warp_core.sv]
// horizontal_offset_warp_core: top level of the one-row horizontal warp.
// Depends on how_pkg, how_row_mem and how_interp.
//
// Usage:
//   req_* carries one item per valid/ready handshake. A load item (opcode 0)
//   writes sample_in at (channel_index, column) and gives no
//   result. A warp item (opcode 1) gives one rsp_* item per channel in use,
//   channel 0 first, with rsp_last set on the final one.
//   csr_* writes channels_in_use (index 0) or width_in_use (index 1); write
//   only while no warp item is in progress.
// Sequencing:
//   A warp item steps through read, multiply, add and present for each
//   channel, then returns to idle before the next item; the single
//   multiplier and the row store with its two read ports set this.
//   req_ready is low for the whole of a warp item.
// Reset: channels_in_use returns to 1 and width_in_use to 128. The row store
//   is not cleared; read only columns that were loaded.
// Stall: while rsp_ready is low the result is held and the sequencer waits.
module horizontal_offset_warp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [3:0]         req_channel_index,
   input  logic [6:0]         req_column,
   input  logic signed [7:0]  req_sample_in,
   input  logic signed [15:0] req_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_out_channel,
   output logic signed [7:0]  rsp_sample_out,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata
);
   import how_pkg::*;

   state_type      state_ff, state_in;
   interp_ctl_type ctl;

   logic [NCH_W-1:0]        chan_cfg_ff;
   logic [WID_W-1:0]        width_cfg_ff;
   logic [NCH_W-1:0]        nch_eff;
   logic [WID_W-1:0]        width_eff;

   logic [NCH_W-1:0]        nch_ff;
   logic [CH_W-1:0]         ch_ff, ch_in;
   logic [COL_W-1:0]        right_ff, left_ff;
   logic                    right_ok_ff, left_ok_ff;
   logic signed [7:0]       frac_ff;
   logic [7:0]              right_in, left_in;
   logic                    req_acc, warp_acc, load_acc, rsp_acc, last_now;
   logic                    rd_en;
   logic signed [7:0]       rd_right, rd_left;
   logic [ADDR_W-1:0]       wr_addr, rd_addr_a, rd_addr_b;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cfg_ff  <= NCH_W'(1);
         width_cfg_ff <= WID_W'(MAX_WIDTH);
      end else if (csr_we) begin
         case (reg_type'(csr_index))
            REG_CHANNELS: chan_cfg_ff  <= csr_wdata[NCH_W-1:0];
            REG_WIDTH:    width_cfg_ff <= csr_wdata[WID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      nch_eff = chan_cfg_ff;
      if (chan_cfg_ff == '0) begin
         nch_eff = NCH_W'(1);
      end else if (chan_cfg_ff > NCH_W'(MAX_CHANNELS)) begin
         nch_eff = NCH_W'(MAX_CHANNELS);
      end
      width_eff = width_cfg_ff;
      if (width_cfg_ff == '0) begin
         width_eff = WID_W'(1);
      end else if (width_cfg_ff > WID_W'(MAX_WIDTH)) begin
         width_eff = WID_W'(MAX_WIDTH);
      end
   end

   assign req_acc  = req_valid && req_ready;
   assign warp_acc = req_acc && (op_type'(req_opcode) == OP_WARP);
   assign load_acc = req_acc && (op_type'(req_opcode) == OP_LOAD)
                     && (int'(req_channel_index) < MAX_CHANNELS)
                     && (int'(req_column) < MAX_WIDTH);
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign last_now = ({1'b0, ch_ff} + NCH_W'(1)) == nch_ff;

   // index arithmetic wraps at 8 bits; an index with the top bit set is out of range
   assign right_in = {1'b0, req_column} - req_offset[15:8];
   assign left_in  = right_in - 8'd1;

   // item registers
   always_ff @(posedge clock) begin
      if (warp_acc) begin
         right_ff    <= right_in[COL_W-1:0];
         left_ff     <= left_in[COL_W-1:0];
         right_ok_ff <= !right_in[7] && (right_in < width_eff);
         left_ok_ff  <= !left_in[7] && (left_in < width_eff);
         frac_ff     <= req_offset[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
         nch_ff   <= NCH_W'(1);
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         if (warp_acc) begin
            nch_ff <= nch_eff;
         end
      end
   end

   always_comb begin
      ch_in = ch_ff;
      if (warp_acc) begin
         ch_in = '0;
      end else if (rsp_acc && !last_now) begin
         ch_in = ch_ff + CH_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (warp_acc) state_in = S_READ;
         end
         S_READ: state_in = S_MUL;
         S_MUL:  state_in = S_ADD;
         S_ADD:  state_in = S_SEND;
         S_SEND: begin
            if (rsp_ready) state_in = last_now ? S_IDLE : S_READ;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      rd_en      = 1'b0;
      ctl.mul_en = 1'b0;
      ctl.add_en = 1'b0;
      case (state_ff)
         S_IDLE: req_ready  = 1'b1;
         S_READ: rd_en      = 1'b1;
         S_MUL:  ctl.mul_en = 1'b1;
         S_ADD:  ctl.add_en = 1'b1;
         S_SEND: rsp_valid  = 1'b1;
         default: ;
      endcase
   end

   assign wr_addr   = {req_channel_index[CH_W-1:0], req_column[COL_W-1:0]};
   assign rd_addr_a = {ch_ff, right_ff};
   assign rd_addr_b = {ch_ff, left_ff};

   how_row_mem u_mem (
      .clock     (clock),
      .wr_en     (load_acc),
      .wr_addr   (wr_addr),
      .wr_data   (req_sample_in),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_right),
      .rd_data_b (rd_left)
   );

   how_interp u_interp (
      .clock    (clock),
      .ctl      (ctl),
      .rd_right (rd_right),
      .rd_left  (rd_left),
      .right_ok (right_ok_ff),
      .left_ok  (left_ok_ff),
      .frac     (frac_ff),
      .sample   (rsp_sample_out)
   );

   assign rsp_out_channel = 4'(ch_ff);
   assign rsp_last        = last_now;

   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result shown while accepting items");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, ch_ff} < nch_ff))
      else $error("result channel beyond channels in use");

   a_warp_start: assert property (@(posedge clock) disable iff (reset)
      warp_acc |=> (state_ff == S_READ) && (ch_ff == '0))
      else $error("warp item did not start at channel zero");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_last |=> req_ready)
      else $error("block not idle after final result");

endmodule

[src/how_row_mem.sv]
// how_row_mem: sample store, one row per channel, one write and two read ports.
// Read data registered. Depends on how_pkg.
module how_row_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [how_pkg::ADDR_W-1:0] wr_addr,
   input  logic signed [7:0]          wr_data,
   input  logic                       rd_en,
   input  logic [how_pkg::ADDR_W-1:0] rd_addr_a,
   input  logic [how_pkg::ADDR_W-1:0] rd_addr_b,
   output logic signed [7:0]          rd_data_a,
   output logic signed [7:0]          rd_data_b
);
   import how_pkg::*;

   logic signed [SMP_W-1:0] mem [DEPTH];
   logic signed [SMP_W-1:0] rd_a_ff;
   logic signed [SMP_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/how_interp.sv]
// how_interp: shared interpolation unit, one multiply then one add per channel.
// Depends on how_pkg.
module how_interp (
   input  logic                    clock,
   input  how_pkg::interp_ctl_type ctl,
   input  logic signed [7:0]       rd_right,
   input  logic signed [7:0]       rd_left,
   input  logic                    right_ok,
   input  logic                    left_ok,
   input  logic signed [7:0]       frac,
   output logic signed [7:0]       sample
);
   import how_pkg::*;

   logic signed [SMP_W-1:0]   r_val;
   logic signed [SMP_W-1:0]   l_val;
   logic signed [SMP_W-1:0]   diff;
   logic signed [2*SMP_W-1:0] prod_in;
   logic signed [2*SMP_W-1:0] prod_ff;
   logic signed [SMP_W-1:0]   r_ff;
   logic [2*SMP_W-1:0]        sum;
   logic signed [SMP_W-1:0]   sample_ff;

   assign r_val   = right_ok ? rd_right : '0;
   assign l_val   = left_ok  ? rd_left  : '0;
   assign diff    = l_val - r_val;
   assign prod_in = diff * frac;
   assign sum     = {r_ff, {FRAC_BITS{1'b0}}} + prod_ff;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
         r_ff    <= r_val;
      end
      if (ctl.add_en) begin
         sample_ff <= sum[FRAC_BITS +: SMP_W];
      end
   end

   assign sample = sample_ff;

endmodule
